// ----- hdl/pse_pkg.sv -----
package pse_pkg;

   // Storage and register file sizing
   localparam int MAX_PARTICLES = 64;
   localparam int MAX_COEFFS    = 5;
   localparam int PIDX_W        = $clog2(MAX_PARTICLES);
   localparam int PCNT_W        = $clog2(MAX_PARTICLES + 1);
   localparam int CSEL_W        = $clog2(MAX_COEFFS);
   localparam int CSR_IDX_W     = $clog2(MAX_COEFFS + 2);
   localparam int CSR_DATA_W    = 32;

   // Field and datapath widths
   localparam int FIELD_W  = 16;
   localparam int WORD_W   = 4 * FIELD_W;
   localparam int WEIGHT_W = 32;
   localparam int ENERGY_W = 48;
   localparam int COEF_W   = 32;
   localparam int NUMC_W   = 3;
   localparam int RADIUS_W = 32;
   localparam int PROD_W   = 2 * FIELD_W;
   localparam int ZSUM_W   = PROD_W + 2;
   localparam int MAG_W    = ZSUM_W - 3;
   localparam int SQ_W     = 62;
   localparam int ROOT_W   = 31;
   localparam int DIST_W   = ROOT_W + 1;
   localparam int DIVN_W   = COEF_W + 28;
   localparam int MUL_W    = 32;
   localparam int WIDE_W   = 64;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_COEF_INVERSE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_NUM_COEFFS   = CSR_IDX_W'(MAX_COEFFS);
   localparam logic [CSR_IDX_W-1:0] REG_INV_RADIUS   = CSR_IDX_W'(MAX_COEFFS + 1);

   localparam logic [NUMC_W-1:0]   NUM_COEFFS_RESET = NUMC_W'(2);
   localparam logic [RADIUS_W-1:0] INV_RADIUS_RESET = 32'h4000_0000;

   // Saturation limits
   localparam logic signed [WIDE_W-1:0] TERM_LIMIT = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [WIDE_W-1:0] ACC_LIMIT  = 64'sh3FFF_FFFF_FFFF_FFFF;
   localparam logic [WIDE_W-1:0]        MUL_CAP    = 64'h4000_0000_0000_0000;
   localparam logic [WIDE_W-1:0]        FIN_HI_MAX = 64'h1000_0000_0000_0000;

   // Shared multiplier operand selection
   typedef enum logic [2:0] {
      MOP_SQA = 3'd0,
      MOP_SQB = 3'd1,
      MOP_PHI = 3'd2,
      MOP_PLO = 3'd3,
      MOP_FHI = 3'd4,
      MOP_FLO = 3'd5
   } mul_op_type;

   typedef struct packed {
      logic              load_item;
      logic              mem_rd;
      logic              mem_wr;
      logic [PIDX_W-1:0] addr;
      logic              calc_prod;
      logic              calc_z;
      logic              mul_en;
      mul_op_type        mul_op;
      logic              sqrt_start;
      logic              div_start;
      logic              recip_load;
      logic              poly_init;
      logic              poly_step;
      logic [CSEL_W-1:0] coef_sel;
      logic              acc_add;
      logic              set_flag;
      logic              fin_done;
   } dp_cmd_type;

   typedef struct packed {
      logic              sqrt_done;
      logic              div_done;
      logic              d_zero;
      logic              rsp_full;
      logic              last;
      logic [NUMC_W-1:0] n_coeffs;
   } dp_stat_type;

endpackage

// ----- hdl/pse_if.sv -----
interface pse_req_if;
   import pse_pkg::*;
   logic                        valid;
   logic                        ready;
   logic signed [FIELD_W-1:0]   u_real;
   logic signed [FIELD_W-1:0]   u_imag;
   logic signed [FIELD_W-1:0]   v_real;
   logic signed [FIELD_W-1:0]   v_imag;
   logic [WEIGHT_W-1:0]         sample_weight;
   logic                        last_particle;

   modport source (output valid, u_real, u_imag, v_real, v_imag, sample_weight,
                   last_particle, input ready);
   modport sink   (input valid, u_real, u_imag, v_real, v_imag, sample_weight,
                   last_particle, output ready);
endinterface

interface pse_rsp_if;
   import pse_pkg::*;
   logic                        valid;
   logic                        ready;
   logic signed [ENERGY_W-1:0]  energy;
   logic [WEIGHT_W-1:0]         weight_out;
   logic                        saturated;

   modport source (output valid, energy, weight_out, saturated, input ready);
   modport sink   (input valid, energy, weight_out, saturated, output ready);
endinterface

// ----- hdl/pairwise_sphere_energy_sum.sv -----
// Pairwise sphere energy sum. Each request is one particle (spinors u, v in
// Q1.15); it is paired with every particle already stored in the current
// configuration, and the pair terms coef_inverse/d + P(d) are accumulated.
// A request marked last_particle produces one response with the energy
// scaled by inv_radius, the passed-through weight and a saturation flag, and
// starts a new configuration. Requests are processed one at a time, and a
// pair at zero distance skips the divider. Each pair runs through a 31-step
// square root and a 60-step radix-2 divider in series, with one shared
// 32x32 multiplier for the squares, the polynomial and the final scaling.
// The response sits in an output register, so the next request is taken
// while it waits; a following last particle waits until it is taken.
// Registers must be written only while the block is idle; the block itself
// does not enforce this.
module pairwise_sphere_energy_sum import pse_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   pse_req_if.sink               req_ch,
   pse_rsp_if.source             rsp_ch,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   pse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pse_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_word         ({req_ch.v_imag, req_ch.v_real, req_ch.u_imag, req_ch.u_real}),
      .req_weight       (req_ch.sample_weight),
      .req_last         (req_ch.last_particle),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_energy       (rsp_ch.energy),
      .rsp_weight_out   (rsp_ch.weight_out),
      .rsp_saturated    (rsp_ch.saturated)
   );

endmodule

// ----- hdl/pse_isqrt.sv -----
module pse_isqrt import pse_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SQ_W-1:0]   operand,
   output logic              done,
   output logic [ROOT_W-1:0] root
);

   logic [SQ_W-1:0] x_ff;
   logic [SQ_W-1:0] res_ff;
   logic [SQ_W-1:0] bit_ff;
   logic            busy_ff;
   logic            done_ff;
   logic [SQ_W:0]   trial;
   logic            fits;

   // One result bit per cycle, digit-by-digit
   assign trial = {1'b0, res_ff} + {1'b0, bit_ff};
   assign fits  = {1'b0, x_ff} >= trial;

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff   <= operand;
         res_ff <= '0;
         bit_ff <= SQ_W'(1) << (SQ_W - 2);
      end else if (busy_ff) begin
         if (fits) begin
            x_ff   <= x_ff - trial[SQ_W-1:0];
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
      end else if (busy_ff && bit_ff[0]) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b1;
      end
   end

   assign done = done_ff;
   assign root = res_ff[ROOT_W-1:0];

endmodule

// ----- hdl/pse_div.sv -----
module pse_div import pse_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVN_W-1:0] num,
   input  logic [DIST_W-1:0] den,
   output logic              done,
   output logic [DIVN_W-1:0] quot
);

   localparam int CNT_W = $clog2(DIVN_W + 1);

   logic [DIVN_W-1:0] q_ff;
   logic [DIST_W-1:0] rem_ff;
   logic [DIST_W-1:0] den_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [DIST_W:0]   shifted;
   logic [DIST_W:0]   diff;
   logic              ge;

   // Restoring divide, one quotient bit per cycle
   assign shifted = {rem_ff, q_ff[DIVN_W-1]};
   assign ge      = shifted >= {1'b0, den_ff};
   assign diff    = shifted - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[DIST_W-1:0] : shifted[DIST_W-1:0];
         q_ff   <= {q_ff[DIVN_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CNT_W'(DIVN_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

// ----- hdl/pse_dp.sv -----
module pse_dp import pse_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data,
   input  logic [WORD_W-1:0]          req_word,
   input  logic [WEIGHT_W-1:0]        req_weight,
   input  logic                       req_last,
   input  dp_cmd_type                 cmd,
   output dp_stat_type                stat,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [ENERGY_W-1:0] rsp_energy,
   output logic [WEIGHT_W-1:0]        rsp_weight_out,
   output logic                       rsp_saturated
);

   function automatic logic [WIDE_W:0] clamp_sym(input logic signed [WIDE_W-1:0] x,
                                                 input logic signed [WIDE_W-1:0] lim);
      logic [WIDE_W:0] r;
      if (x > lim)       r = {1'b1, lim};
      else if (x < -lim) r = {1'b1, -lim};
      else               r = {1'b0, x};
      return r;
   endfunction

   // Configuration registers
   logic signed [COEF_W-1:0] coef_ff [MAX_COEFFS];
   logic [NUMC_W-1:0]        num_coeffs_ff;
   logic [RADIUS_W-1:0]      inv_radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_COEFFS; i++) coef_ff[i] <= '0;
         num_coeffs_ff <= NUM_COEFFS_RESET;
         inv_radius_ff <= INV_RADIUS_RESET;
      end else if (csr_write_enable) begin
         for (int i = 0; i < MAX_COEFFS; i++)
            if (csr_index == CSR_IDX_W'(i)) coef_ff[i] <= csr_data[COEF_W-1:0];
         if (csr_index == REG_NUM_COEFFS) num_coeffs_ff <= csr_data[NUMC_W-1:0];
         if (csr_index == REG_INV_RADIUS) inv_radius_ff <= csr_data[RADIUS_W-1:0];
      end
   end

   // Current request
   logic [WORD_W-1:0]   word_ff;
   logic [WEIGHT_W-1:0] weight_ff;
   logic                last_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         word_ff   <= req_word;
         weight_ff <= req_weight;
         last_ff   <= req_last;
      end
   end

   // Particle store
   logic [WORD_W-1:0] store_mem [MAX_PARTICLES];
   logic [WORD_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.mem_wr) store_mem[cmd.addr] <= word_ff;
      if (cmd.mem_rd) rd_ff <= store_mem[cmd.addr];
   end

   // Cross products of the spinor pair
   logic signed [FIELD_W-1:0] aur, aui, avr, avi, bur, bui, bvr, bvi;
   logic signed [PROD_W-1:0]  prod_ff [8];

   assign aur = word_ff[FIELD_W-1:0];
   assign aui = word_ff[2*FIELD_W-1:FIELD_W];
   assign avr = word_ff[3*FIELD_W-1:2*FIELD_W];
   assign avi = word_ff[4*FIELD_W-1:3*FIELD_W];
   assign bur = rd_ff[FIELD_W-1:0];
   assign bui = rd_ff[2*FIELD_W-1:FIELD_W];
   assign bvr = rd_ff[3*FIELD_W-1:2*FIELD_W];
   assign bvi = rd_ff[4*FIELD_W-1:3*FIELD_W];

   always_ff @(posedge clock) begin
      if (cmd.calc_prod) begin
         prod_ff[0] <= aur * bvr;
         prod_ff[1] <= aui * bvi;
         prod_ff[2] <= bur * avr;
         prod_ff[3] <= bui * avi;
         prod_ff[4] <= aur * bvi;
         prod_ff[5] <= aui * bvr;
         prod_ff[6] <= bur * avi;
         prod_ff[7] <= bui * avr;
      end
   end

   // z = u_i*v_j - u_j*v_i, magnitudes in units of 2^-28
   logic signed [ZSUM_W-1:0] zr, zi;
   logic [ZSUM_W-1:0]        zr_mag, zi_mag;
   logic [MAG_W-1:0]         a_ff, b_ff;

   assign zr = ZSUM_W'(prod_ff[0]) - ZSUM_W'(prod_ff[1])
             - ZSUM_W'(prod_ff[2]) + ZSUM_W'(prod_ff[3]);
   assign zi = ZSUM_W'(prod_ff[4]) + ZSUM_W'(prod_ff[5])
             - ZSUM_W'(prod_ff[6]) - ZSUM_W'(prod_ff[7]);
   assign zr_mag = zr[ZSUM_W-1] ? ZSUM_W'(-zr) : ZSUM_W'(zr);
   assign zi_mag = zi[ZSUM_W-1] ? ZSUM_W'(-zi) : ZSUM_W'(zi);

   always_ff @(posedge clock) begin
      if (cmd.calc_z) begin
         a_ff <= zr_mag[MAG_W+1:2];
         b_ff <= zi_mag[MAG_W+1:2];
      end
   end

   // Term and accumulator registers
   logic signed [ENERGY_W-1:0] p_ff;
   logic signed [ENERGY_W-1:0] r_ff;
   logic signed [WIDE_W-1:0]   acc_ff;
   logic                       flag_ff;
   logic [ENERGY_W-1:0]        p_mag;
   logic [WIDE_W-1:0]          acc_mag;

   assign p_mag   = p_ff[ENERGY_W-1] ? ENERGY_W'(-p_ff) : ENERGY_W'(p_ff);
   assign acc_mag = acc_ff[WIDE_W-1] ? WIDE_W'(-acc_ff) : WIDE_W'(acc_ff);

   // Square root and distance
   logic [ROOT_W-1:0] root;
   logic [DIST_W-1:0] chord_dist;
   logic              sqrt_done;
   logic [WIDE_W-1:0] mul_ff;
   logic [WIDE_W-1:0] hi_ff;
   logic [SQ_W-1:0]   sq_sum;

   assign sq_sum     = hi_ff[SQ_W-1:0] + mul_ff[SQ_W-1:0];
   assign chord_dist = {root, 1'b0};

   pse_isqrt u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.sqrt_start),
      .operand (sq_sum),
      .done    (sqrt_done),
      .root    (root)
   );

   // Shared multiplier, result registered
   logic [MUL_W-1:0] mul_a, mul_b;

   always_comb begin
      case (cmd.mul_op)
         MOP_SQA: begin
            mul_a = MUL_W'(a_ff);
            mul_b = MUL_W'(a_ff);
         end
         MOP_SQB: begin
            mul_a = MUL_W'(b_ff);
            mul_b = MUL_W'(b_ff);
         end
         MOP_PHI: begin
            mul_a = MUL_W'(p_mag[ENERGY_W-1:MUL_W]);
            mul_b = chord_dist;
         end
         MOP_PLO: begin
            mul_a = p_mag[MUL_W-1:0];
            mul_b = chord_dist;
         end
         MOP_FHI: begin
            mul_a = acc_mag[WIDE_W-1:MUL_W];
            mul_b = inv_radius_ff;
         end
         MOP_FLO: begin
            mul_a = acc_mag[MUL_W-1:0];
            mul_b = inv_radius_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         mul_ff <= WIDE_W'(mul_a) * WIDE_W'(mul_b);
         hi_ff  <= mul_ff;
      end
   end

   // Reciprocal term
   logic signed [COEF_W-1:0] c0;
   logic [COEF_W-1:0]        c0_mag;
   logic [DIVN_W-1:0]        quot;
   logic                     div_done;
   logic                     q_big;
   logic [ENERGY_W-2:0]      r_mag;
   logic signed [ENERGY_W-1:0] r_in;
   logic                     recip_sat;

   assign c0     = coef_ff[0];
   assign c0_mag = c0[COEF_W-1] ? COEF_W'(-c0) : COEF_W'(c0);

   pse_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   ({c0_mag, 28'd0}),
      .den   (chord_dist),
      .done  (div_done),
      .quot  (quot)
   );

   always_comb begin
      q_big = quot > TERM_LIMIT[DIVN_W-1:0];
      if (root == '0) r_mag = (c0 == '0) ? '0 : TERM_LIMIT[ENERGY_W-2:0];
      else if (q_big) r_mag = TERM_LIMIT[ENERGY_W-2:0];
      else            r_mag = quot[ENERGY_W-2:0];
      r_in      = c0[COEF_W-1] ? -$signed({1'b0, r_mag}) : $signed({1'b0, r_mag});
      recip_sat = (root == '0) || q_big;
   end

   // Horner step: p = clamp(p*d/2^28 + coef[k])
   logic [WIDE_W-1:0]        poly_m;
   logic signed [WIDE_W-1:0] poly_s;
   logic signed [WIDE_W-1:0] poly_sum;
   logic [WIDE_W:0]          poly_cl;
   logic signed [COEF_W-1:0] coef_sel_val;

   assign coef_sel_val = coef_ff[cmd.coef_sel];
   assign poly_m   = (hi_ff << 4) + (mul_ff >> 28);
   assign poly_s   = p_ff[ENERGY_W-1] ? -$signed(poly_m) : $signed(poly_m);
   assign poly_sum = poly_s + WIDE_W'(coef_sel_val);
   assign poly_cl  = clamp_sym(poly_sum, TERM_LIMIT);

   // Accumulate pair term
   logic signed [WIDE_W-1:0] acc_sum;
   logic [WIDE_W:0]          acc_cl;

   assign acc_sum = acc_ff + WIDE_W'(r_ff) + WIDE_W'(p_ff);
   assign acc_cl  = clamp_sym(acc_sum, ACC_LIMIT);

   // Final scaling by inverse radius
   logic [WIDE_W-1:0]          fin_sum;
   logic                       fin_cap;
   logic [WIDE_W-1:0]          fin_m;
   logic                       fin_big;
   logic [ENERGY_W-2:0]        fin_mag;
   logic signed [ENERGY_W-1:0] energy_in;

   always_comb begin
      fin_sum   = (hi_ff << 2) + (mul_ff >> 30);
      fin_cap   = (hi_ff > FIN_HI_MAX) || (fin_sum > MUL_CAP);
      fin_m     = fin_cap ? MUL_CAP : fin_sum;
      fin_big   = fin_m > WIDE_W'(TERM_LIMIT);
      fin_mag   = fin_big ? TERM_LIMIT[ENERGY_W-2:0] : fin_m[ENERGY_W-2:0];
      energy_in = acc_ff[WIDE_W-1] ? -$signed({1'b0, fin_mag}) : $signed({1'b0, fin_mag});
   end

   always_ff @(posedge clock) begin
      if (cmd.recip_load) r_ff <= r_in;
      if (cmd.poly_init)      p_ff <= ENERGY_W'(coef_sel_val);
      else if (cmd.poly_step) p_ff <= poly_cl[ENERGY_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         flag_ff <= 1'b0;
      end else if (cmd.fin_done) begin
         acc_ff  <= '0;
         flag_ff <= 1'b0;
      end else begin
         if (cmd.acc_add) acc_ff <= acc_cl[WIDE_W-1:0];
         if (cmd.set_flag || (cmd.recip_load && recip_sat) ||
             (cmd.poly_step && poly_cl[WIDE_W]) || (cmd.acc_add && acc_cl[WIDE_W]))
            flag_ff <= 1'b1;
      end
   end

   // Output register
   logic                       rsp_valid_ff;
   logic signed [ENERGY_W-1:0] energy_ff;
   logic [WEIGHT_W-1:0]        weight_out_ff;
   logic                       sat_ff;

   always_ff @(posedge clock) begin
      if (cmd.fin_done) begin
         energy_ff     <= energy_in;
         weight_out_ff <= weight_ff;
         sat_ff        <= flag_ff | fin_cap | fin_big;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)              rsp_valid_ff <= 1'b0;
      else if (cmd.fin_done)  rsp_valid_ff <= 1'b1;
      else if (rsp_ready)     rsp_valid_ff <= 1'b0;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_energy     = energy_ff;
   assign rsp_weight_out = weight_out_ff;
   assign rsp_saturated  = sat_ff;

   // Status to controller
   always_comb begin
      stat.sqrt_done = sqrt_done;
      stat.div_done  = div_done;
      stat.d_zero    = (root == '0);
      stat.rsp_full  = rsp_valid_ff;
      stat.last      = last_ff;
      if (num_coeffs_ff < NUMC_W'(2))               stat.n_coeffs = NUMC_W'(2);
      else if (num_coeffs_ff > NUMC_W'(MAX_COEFFS)) stat.n_coeffs = NUMC_W'(MAX_COEFFS);
      else                                          stat.n_coeffs = num_coeffs_ff;
   end

endmodule

// ----- hdl/pse_ctrl.sv -----
module pse_ctrl import pse_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [19:0] {
      ST_IDLE  = 20'h00001,
      ST_READ  = 20'h00002,
      ST_PROD  = 20'h00004,
      ST_ZSUM  = 20'h00008,
      ST_SQA   = 20'h00010,
      ST_SQB   = 20'h00020,
      ST_SQS   = 20'h00040,
      ST_SQW   = 20'h00080,
      ST_DIVS  = 20'h00100,
      ST_DIVW  = 20'h00200,
      ST_RECIP = 20'h00400,
      ST_PHI   = 20'h00800,
      ST_PLO   = 20'h01000,
      ST_PCOMB = 20'h02000,
      ST_ACC   = 20'h04000,
      ST_STORE = 20'h08000,
      ST_CHECK = 20'h10000,
      ST_FHI   = 20'h20000,
      ST_FLO   = 20'h40000,
      ST_FOUT  = 20'h80000
   } state_type;

   state_type         state_ff, state_in;
   logic [PCNT_W-1:0] count_ff, count_in;
   logic [PIDX_W-1:0] j_ff, j_in;
   logic [CSEL_W-1:0] k_ff, k_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

   // Sequencer: one pair at a time through the shared units
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      cmd       = '0;
      cmd.addr  = j_ff;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               if (count_ff == PCNT_W'(MAX_PARTICLES)) begin
                  cmd.set_flag = 1'b1;
                  state_in     = ST_CHECK;
               end else if (count_ff == '0) begin
                  state_in = ST_STORE;
               end else begin
                  j_in     = '0;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            cmd.mem_rd = 1'b1;
            state_in   = ST_PROD;
         end
         ST_PROD: begin
            cmd.calc_prod = 1'b1;
            state_in      = ST_ZSUM;
         end
         ST_ZSUM: begin
            cmd.calc_z = 1'b1;
            state_in   = ST_SQA;
         end
         ST_SQA: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MOP_SQA;
            state_in   = ST_SQB;
         end
         ST_SQB: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MOP_SQB;
            state_in   = ST_SQS;
         end
         ST_SQS: begin
            cmd.sqrt_start = 1'b1;
            state_in       = ST_SQW;
         end
         ST_SQW: begin
            if (stat.sqrt_done) state_in = ST_DIVS;
         end
         ST_DIVS: begin
            if (stat.d_zero) begin
               state_in = ST_RECIP;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIVW;
            end
         end
         ST_DIVW: begin
            if (stat.div_done) state_in = ST_RECIP;
         end
         ST_RECIP: begin
            cmd.recip_load = 1'b1;
            cmd.poly_init  = 1'b1;
            cmd.coef_sel   = CSEL_W'(stat.n_coeffs - NUMC_W'(1));
            if (stat.n_coeffs == NUMC_W'(2)) begin
               state_in = ST_ACC;
            end else begin
               k_in     = CSEL_W'(stat.n_coeffs - NUMC_W'(2));
               state_in = ST_PHI;
            end
         end
         ST_PHI: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MOP_PHI;
            state_in   = ST_PLO;
         end
         ST_PLO: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MOP_PLO;
            state_in   = ST_PCOMB;
         end
         ST_PCOMB: begin
            cmd.poly_step = 1'b1;
            cmd.coef_sel  = k_ff;
            if (k_ff == CSEL_W'(1)) begin
               state_in = ST_ACC;
            end else begin
               k_in     = k_ff - CSEL_W'(1);
               state_in = ST_PHI;
            end
         end
         ST_ACC: begin
            cmd.acc_add = 1'b1;
            if (PCNT_W'(j_ff) + PCNT_W'(1) == count_ff) begin
               state_in = ST_STORE;
            end else begin
               j_in     = j_ff + PIDX_W'(1);
               state_in = ST_READ;
            end
         end
         ST_STORE: begin
            cmd.mem_wr = 1'b1;
            cmd.addr   = count_ff[PIDX_W-1:0];
            count_in   = count_ff + PCNT_W'(1);
            state_in   = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = stat.last ? ST_FHI : ST_IDLE;
         end
         ST_FHI: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MOP_FHI;
            state_in   = ST_FLO;
         end
         ST_FLO: begin
            cmd.mul_en = 1'b1;
            cmd.mul_op = MOP_FLO;
            state_in   = ST_FOUT;
         end
         ST_FOUT: begin
            if (!stat.rsp_full) begin
               cmd.fin_done = 1'b1;
               count_in     = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- hdl/pse_checker.sv -----
module pse_checker import pse_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [ENERGY_W-1:0] rsp_energy,
   input logic [WEIGHT_W-1:0]        rsp_weight_out,
   input logic                       rsp_saturated
);

   // Comes out of reset idle and empty
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("not idle after reset");

   // One request at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   // Energy is clamped symmetrically
   a_energy_sym: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_energy != 48'sh8000_0000_0000))
      else $error("energy outside symmetric range");

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_energy) && $stable(rsp_weight_out) &&
          $stable(rsp_saturated)))
      else $error("stalled response changed");

endmodule

bind pairwise_sphere_energy_sum pse_checker u_pse_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_energy     (rsp_ch.energy),
   .rsp_weight_out (rsp_ch.weight_out),
   .rsp_saturated  (rsp_ch.saturated)
);
